@@ rtl/sle_pkg.sv @@
package sle_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_QUOTE = 2'd1;
    localparam logic [1:0] KIND_EOI   = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // Default output queue address width (depth 4)
    localparam int QUEUE_AW_DEF = 2;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_BODY = 5'b00010,
        MODE_ESC  = 5'b00100,
        MODE_HEX1 = 5'b01000,
        MODE_HEX2 = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
        logic       begin_req;
        logic [7:0] delimiter;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] end_kind;
        logic       last;
    } res_item_t;

    // Decoder to queue: up to two results per input item
    typedef struct packed {
        logic [1:0] count;
        res_item_t  res0;
        res_item_t  res1;
    } dec_push_t;

    // Queue status back to the top level
    typedef struct packed {
        logic room;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/sle_decode.sv @@
module sle_decode
    import sle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  src_item_t item,
    output dec_push_t push
);

    mode_t      mode_reg, mode_next;
    logic [3:0] hex_high_reg, hex_high_next;
    logic [7:0] quote_reg, quote_next;

    // Returns 0..15, or bit 4 set when not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] u;
        u = b & ~CASE_BIT;
        if (b >= 8'h30 && b <= 8'h39)
            return {1'b0, 4'(b - 8'h30)};
        else if (u >= 8'h41 && u <= 8'h46)
            return {1'b0, 4'(u - 8'h41 + 8'd10)};
        else
            return 5'h10;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        unique case (b)
            8'h61:   return 8'h07;
            8'h62:   return 8'h08;
            8'h66:   return 8'h0C;
            8'h6E:   return 8'h0A;
            8'h72:   return 8'h0D;
            8'h74:   return 8'h09;
            8'h76:   return 8'h0B;
            default: return b;
        endcase
    endfunction

    mode_t      cur_mode;
    logic [7:0] quote_eff;
    logic [7:0] b;
    logic [4:0] hv;
    logic [7:0] v;

    always_comb
    begin
        b             = item.in_byte;
        cur_mode      = item.begin_req ? MODE_BODY : mode_reg;
        quote_eff     = item.begin_req ? item.delimiter : quote_reg;
        quote_next    = quote_eff;
        mode_next     = cur_mode;
        hex_high_next = hex_high_reg;
        hv            = hex_value(b);
        v             = {hex_high_reg, 4'h0};
        push.count    = 2'd0;
        push.res0     = '{out_byte: b, end_kind: KIND_DATA, last: 1'b0};
        push.res1     = '{out_byte: quote_eff, end_kind: KIND_EOI, last: 1'b1};

        unique case (cur_mode)
            MODE_BODY:
            begin
                if (item.at_end || b == quote_eff || b != CHAR_BSLASH)
                    push.count = 2'd1;
                if (item.at_end)
                begin
                    push.res0 = '{out_byte: quote_eff, end_kind: KIND_EOI, last: 1'b1};
                    mode_next = MODE_IDLE;
                end
                else if (b == quote_eff)
                begin
                    push.res0 = '{out_byte: quote_eff, end_kind: KIND_QUOTE, last: 1'b1};
                    mode_next = MODE_IDLE;
                end
                else if (b == CHAR_BSLASH)
                    mode_next = MODE_ESC;
            end
            MODE_ESC:
            begin
                if (item.at_end)
                begin
                    push.count = 2'd1;
                    push.res0  = '{out_byte: quote_eff, end_kind: KIND_EOI, last: 1'b1};
                    mode_next  = MODE_IDLE;
                end
                else if (b == CHAR_NUL)
                begin
                    push.count = 2'd1;
                    push.res0  = '{out_byte: quote_eff, end_kind: KIND_BAD, last: 1'b1};
                    mode_next  = MODE_IDLE;
                end
                else if (b == CHAR_X)
                    mode_next = MODE_HEX1;
                else
                begin
                    push.count = 2'd1;
                    push.res0  = '{out_byte: esc_map(b), end_kind: KIND_DATA, last: 1'b0};
                    mode_next  = MODE_BODY;
                end
            end
            MODE_HEX1:
            begin
                if (item.at_end || hv[4])
                begin
                    push.count = 2'd1;
                    push.res0  = '{out_byte: quote_eff,
                                   end_kind: item.at_end ? KIND_EOI : KIND_BAD,
                                   last: 1'b1};
                    mode_next  = MODE_IDLE;
                end
                else
                begin
                    hex_high_next = hv[3:0];
                    mode_next     = MODE_HEX2;
                end
            end
            MODE_HEX2:
            begin
                mode_next = MODE_IDLE;
                if (item.at_end)
                begin
                    if (v != 8'h00)
                    begin
                        // digit emitted as data, then the ending
                        push.count = 2'd2;
                        push.res0  = '{out_byte: v, end_kind: KIND_DATA, last: 1'b0};
                    end
                    else
                    begin
                        push.count = 2'd1;
                        push.res0  = '{out_byte: quote_eff, end_kind: KIND_EOI, last: 1'b1};
                    end
                end
                else
                begin
                    if (!hv[4])
                        v = v | {4'h0, hv[3:0]};
                    push.count = 2'd1;
                    if (v == 8'h00)
                        push.res0 = '{out_byte: quote_eff, end_kind: KIND_BAD, last: 1'b1};
                    else
                    begin
                        push.res0 = '{out_byte: v, end_kind: KIND_DATA, last: 1'b0};
                        mode_next = MODE_BODY;
                    end
                end
            end
            default:
                mode_next = MODE_IDLE;
        endcase

        if (!fire)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            hex_high_reg <= 4'h0;
            quote_reg    <= 8'h00;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            hex_high_reg <= hex_high_next;
            quote_reg    <= quote_next;
        end
    end

endmodule

@@ rtl/sle_out_queue.sv @@
module sle_out_queue
    import sle_pkg::*;
#(
    parameter int AW = QUEUE_AW_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  dec_push_t push,
    output q_status_t status,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    localparam int DEPTH = 1 << AW;
    localparam int CW    = AW + 1;

    res_item_t         entry_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              pop;
    logic [AW-1:0]     wr_ptr_1;

    assign pop          = res_valid && !res_stall;
    assign res_valid    = (count_reg != '0);
    assign res_item     = entry_reg[rd_ptr_reg];
    assign wr_ptr_1     = wr_ptr_reg + AW'(1);
    assign status.room  = (count_reg <= CW'(DEPTH - 2));
    assign status.empty = (count_reg == '0);
    assign count_next   = count_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg + CW'(push.count) <= CW'(DEPTH))
        else $error("output queue overflow");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_next))
        else $error("queue count out of step");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty && push.count == 2'd0 |=> !res_valid)
        else $error("result shown from empty queue");
`endif

endmodule

@@ rtl/string_literal_unescape_unit.sv @@
// Channel  Dir  Payload      Handshake             Accepted when
// byte     in   src_item_t   byte_valid/byte_stall byte_valid && !byte_stall
// res      out  res_item_t   res_valid/res_stall   res_valid && !res_stall
//
// One source item per cycle while byte_stall is low; each gives zero, one or two result items.
// Path: the item is held in the input register, then decoded into the
// output queue, from which its results are offered on the res channel.
// Reset (rst_n low, async) clears the decode state, the input register
// valid and the queue pointers; no string is open after reset.
// byte_stall rises while a held item waits for queue room; the queue
// (four entries by default) absorbs short res_stall bursts before they
// reach the input.
module string_literal_unescape_unit
    import sle_pkg::*;
#(
    parameter int QUEUE_AW = QUEUE_AW_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  src_item_t byte_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    // Input register
    logic      in_valid_reg, in_valid_next;
    src_item_t in_item_reg;

    logic      accept;
    logic      fire;      // held item decoded this cycle
    dec_push_t push;
    q_status_t q_status;

    // Decode only when the queue can take two results
    assign fire          = in_valid_reg && q_status.room;
    assign byte_stall    = in_valid_reg && !q_status.room;
    assign accept        = byte_valid && !byte_stall;
    assign in_valid_next = accept || (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= byte_item;
    end

    // Escape decoder with mode, hex digit and quote registers
    sle_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .push  (push)
    );

    // Result queue, doubles as the output register
    sle_out_queue #(
        .AW (QUEUE_AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .status    (q_status),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.res1.last && !push.res0.last)
        else $error("two-result item out of order");
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> push.res0.last == (push.res0.end_kind != KIND_DATA))
        else $error("last flag disagrees with kind");
    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("held item lost");
`endif

endmodule

@@ sim/tb_string_literal_unescape_unit.sv @@
`timescale 1ns / 100ps

module tb_string_literal_unescape_unit;
    import sle_pkg::*;

    // Escape letters and their control codes
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_V = 8'h76;
    localparam logic [7:0] CH_Q = 8'h71;
    localparam logic [7:0] CH_Z = 8'h7A;
    localparam logic [7:0] CH_G = 8'h67;

    // Hex digit ranges
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_5  = 8'h35;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [4:0] HEX_NONE = 5'h10;

    // Usual quote bytes
    localparam logic [7:0] QUOTE_DQ = 8'h22;
    localparam logic [7:0] QUOTE_SQ = 8'h27;

    localparam int RESET_CYCLES = 8;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int TARGET_ITEMS = 900;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    src_item_t byte_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    string_literal_unescape_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    // Predictor state: mirrors the decoder's mode, hex digit and quote
    mode_t      str_mode;
    logic [3:0] hex_hi;
    logic [7:0] quote_q;

    // Results the decoder owes us, oldest first
    res_item_t decoded_queue[$];

    int err_count;
    int decoded_items;      // items that hit an open string (ignored ones excluded)
    int strings_opened;
    int results_checked;
    int kind_count[4];
    int input_stall_cycles;

    // Idle controls: sender gaps, receiver stall bursts, one long hold
    bit src_idle_on;
    bit res_idle_on;
    bit long_hold_req;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Digit value 0..15, or HEX_NONE when b is not a hex digit
    function automatic logic [4:0] hex_digit_value(input logic [7:0] b);
        logic [7:0] up;
        logic [7:0] t;
        up = b & ~CASE_BIT;
        if (b >= CH_0 && b <= CH_9)
        begin
            t = b - CH_0;
            return {1'b0, t[3:0]};
        end
        if (up >= CH_UA && up <= CH_UF)
        begin
            t = up - CH_UA + 8'd10;
            return {1'b0, t[3:0]};
        end
        return HEX_NONE;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] b);
        case (b)
            CH_A:    return 8'h07;
            CH_B:    return 8'h08;
            CH_F:    return 8'h0C;
            CH_N:    return 8'h0A;
            CH_R:    return 8'h0D;
            CH_T:    return 8'h09;
            CH_V:    return 8'h0B;
            default: return b;  // anything else stands for itself
        endcase
    endfunction

    task automatic push_result(input logic [7:0] b, input logic [1:0] kind,
                               input logic lst);
        res_item_t r;
        r.out_byte = b;
        r.end_kind = kind;
        r.last     = lst;
        decoded_queue.push_back(r);
    endtask

    // Ending result always carries the quote byte
    task automatic close_string(input logic [1:0] kind);
        push_result(quote_q, kind, 1'b1);
        str_mode = MODE_IDLE;
    endtask

    task automatic decode_item(input src_item_t it);
        logic [7:0] v;
        logic [4:0] d;
        if (it.begin_req)
        begin
            // a string still open is dropped silently
            quote_q  = it.delimiter;
            str_mode = MODE_BODY;
            strings_opened++;
        end
        if (str_mode != MODE_IDLE)
            decoded_items++;
        case (str_mode)
            MODE_BODY:
            begin
                // end of input first, then quote, then backslash
                if (it.at_end)
                    close_string(KIND_EOI);
                else if (it.in_byte == quote_q)
                    close_string(KIND_QUOTE);
                else if (it.in_byte == CHAR_BSLASH)
                    str_mode = MODE_ESC;
                else
                    push_result(it.in_byte, KIND_DATA, 1'b0);
            end
            MODE_ESC:
            begin
                if (it.at_end)
                    close_string(KIND_EOI);
                else if (it.in_byte == CHAR_NUL)
                    close_string(KIND_BAD);
                else if (it.in_byte == CHAR_X)
                    str_mode = MODE_HEX1;
                else
                begin
                    push_result(escape_map(it.in_byte), KIND_DATA, 1'b0);
                    str_mode = MODE_BODY;
                end
            end
            MODE_HEX1:
            begin
                d = hex_digit_value(it.in_byte);
                if (it.at_end)
                    close_string(KIND_EOI);
                else if (d == HEX_NONE)
                    close_string(KIND_BAD);     // bad digit is consumed
                else
                begin
                    hex_hi   = d[3:0];
                    str_mode = MODE_HEX2;
                end
            end
            MODE_HEX2:
            begin
                v = {hex_hi, 4'h0};
                d = hex_digit_value(it.in_byte);
                if (it.at_end)
                begin
                    // single digit at end of input: data (if nonzero) then ending
                    if (v != 8'h00)
                        push_result(v, KIND_DATA, 1'b0);
                    close_string(KIND_EOI);
                end
                else
                begin
                    // a non-digit here still gets consumed
                    if (d != HEX_NONE)
                        v[3:0] = d[3:0];
                    if (v == 8'h00)
                        close_string(KIND_BAD);
                    else
                    begin
                        push_result(v, KIND_DATA, 1'b0);
                        str_mode = MODE_BODY;
                    end
                end
            end
            default:
                str_mode = MODE_IDLE;   // idle without begin: ignored
        endcase
    endtask

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Drive one item at the falling edge, hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic at_end,
                             input logic begin_req, input logic [7:0] delim);
        src_item_t it;
        it.in_byte   = b;
        it.at_end    = at_end;
        it.begin_req = begin_req;
        it.delimiter = delim;
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            byte_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        byte_valid = 1'b1;
        byte_item  = it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        decode_item(it);
    endtask

    task automatic send_body(input logic [7:0] b);
        send_item(b, 1'b0, 1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_eoi();
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic open_string(input logic [7:0] q, input logic [7:0] first);
        send_item(first, 1'b0, 1'b1, q);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic check_result(input res_item_t got);
        res_item_t exp;
        results_checked++;
        kind_count[got.end_kind]++;
        if (decoded_queue.size() == 0)
        begin
            $error("unexpected result: out_byte=%h end_kind=%0d last=%0b",
                   got.out_byte, got.end_kind, got.last);
            err_count++;
            return;
        end
        exp = decoded_queue.pop_front();
        if (got.out_byte !== exp.out_byte)
        begin
            $error("out_byte: expected %h, got %h", exp.out_byte, got.out_byte);
            err_count++;
        end
        if (got.end_kind !== exp.end_kind)
        begin
            $error("end_kind: expected %0d, got %0d", exp.end_kind, got.end_kind);
            err_count++;
        end
        if (got.last !== exp.last)
        begin
            $error("last: expected %0b, got %0b", exp.last, got.last);
            err_count++;
        end
    endtask

    // Sample at the rising edge; count cycles where the input was held off
    initial
    begin : result_monitor
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (byte_valid && byte_stall)
                input_stall_cycles++;
            if (res_valid && !res_stall)
                check_result(res_item);
        end
    end

    // Receiver stall: random bursts, or one long hold on request
    initial
    begin : result_stall_driver
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_stall     = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                res_stall = 1'b0;
            end
            else if (res_idle_on && $urandom_range(0, 4) == 0)
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                res_stall = 1'b0;
            end
            else
                res_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Byte and delimiter extremes, plus an item with no string open
    task automatic test_plain_bytes();
        send_item(8'hFF, 1'b0, 1'b0, 8'h00);    // idle: ignored
        open_string(8'h00, 8'hFF);              // 0xFF is plain data
        send_body(8'h00);                       // closes on 0x00
        open_string(8'hFF, 8'h00);              // 0x00 in the body is data
        send_body(8'h80);
        send_body(8'hFF);                       // closes on 0xFF
    endtask

    task automatic test_escapes();
        open_string(QUOTE_DQ, CHAR_BSLASH);
        send_body(CH_N);
        send_body(CHAR_BSLASH);
        send_body(QUOTE_DQ);                    // escaped quote is data
        send_body(CHAR_BSLASH);
        send_body(CH_Q);                        // unknown escape passes through
        send_body(QUOTE_DQ);
    endtask

    task automatic test_hex_escapes();
        open_string(QUOTE_SQ, CHAR_BSLASH);
        send_body(CHAR_X);
        send_body(CH_A);                        // lowercase digit
        send_body(CH_UF);                       // uppercase digit
        send_body(CHAR_BSLASH);
        send_body(CHAR_X);
        send_body(CH_7);
        send_body(CH_Z);                        // single digit, z swallowed
        send_body(CHAR_BSLASH);
        send_body(CHAR_X);
        send_body(CH_0);
        send_body(CH_0);                        // decodes to zero: bad
    endtask

    task automatic test_endings();
        // end of input right after a backslash
        open_string(QUOTE_DQ, CHAR_BSLASH);
        send_eoi();
        // single nonzero digit then end of input: data plus ending
        open_string(QUOTE_DQ, CHAR_BSLASH);
        send_body(CHAR_X);
        send_body(CH_5);
        send_eoi();
        // single zero digit then end of input: ending only
        open_string(QUOTE_DQ, CHAR_BSLASH);
        send_body(CHAR_X);
        send_body(CH_0);
        send_eoi();
        // bad first hex digit, then a NUL escape after a dropped string
        open_string(QUOTE_SQ, CHAR_BSLASH);
        send_body(CHAR_X);
        send_body(CH_G);
        open_string(QUOTE_DQ, CH_B);
        open_string(QUOTE_SQ, CHAR_BSLASH);     // drops the open string
        send_body(CHAR_NUL);
        // quote byte is a backslash: it closes instead of escaping
        open_string(CHAR_BSLASH, CHAR_BSLASH);
        // begin and end of input together
        send_item(8'h5A, 1'b1, 1'b1, QUOTE_DQ);
    endtask

    // Receiver holds off while the sender streams data into the block
    task automatic test_backpressure();
        src_idle_on   = 1'b0;
        res_idle_on   = 1'b0;
        long_hold_req = 1'b1;
        open_string(QUOTE_DQ, CH_A);
        repeat (46) send_body(CH_B + 8'($urandom_range(0, 15)));
        send_body(QUOTE_DQ);
    endtask

    function automatic logic [7:0] rand_hex_digit();
        logic [3:0] d;
        d = 4'($urandom_range(0, 15));
        if (d < 4'd10)
            return CH_0 + 8'(d);
        if ($urandom_range(0, 1) == 0)
            return CH_UA + 8'(d) - 8'd10;
        return (CH_UA + 8'(d) - 8'd10) | CASE_BIT;
    endfunction

    function automatic logic [7:0] rand_plain(input logic [7:0] q);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == q || b == CHAR_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (hex_digit_value(b) != HEX_NONE);
        return b;
    endfunction

    // One body token: plain byte, escape, hex escape or escaped quote
    task automatic send_token(input logic [7:0] q);
        logic [7:0] esc_set[7];
        logic [7:0] other;
        esc_set = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                send_body(rand_plain(q));
            5:
            begin
                send_body(CHAR_BSLASH);
                if ($urandom_range(0, 1) == 0)
                    send_body(esc_set[$urandom_range(0, 6)]);
                else
                begin
                    other = 8'($urandom_range(1, 255));
                    send_body(other == CHAR_X ? CH_Q : other);
                end
            end
            6, 7:
            begin
                send_body(CHAR_BSLASH);
                send_body(CHAR_X);
                send_body(rand_hex_digit());
                send_body(rand_hex_digit());
            end
            8:
            begin
                // one digit, then any non-digit byte gets eaten
                send_body(CHAR_BSLASH);
                send_body(CHAR_X);
                send_body(rand_hex_digit());
                send_body(rand_non_hex());
            end
            default:
            begin
                send_body(CHAR_BSLASH);
                send_body(q);
            end
        endcase
    endtask

    // Mostly well-formed strings with random content; some broken ones
    task automatic test_random_strings(input int target);
        logic [7:0] q;
        bit         calm;
        while (decoded_items < target)
        begin
            // last stretch runs with no idling on either side
            calm        = (decoded_items > target - 150);
            src_idle_on = !calm && ($urandom_range(0, 3) != 0);
            res_idle_on = !calm && ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, 8'($urandom_range(0, 255)));

            case ($urandom_range(0, 3))
                0:       q = QUOTE_DQ;
                1:       q = QUOTE_SQ;
                default: q = 8'($urandom_range(0, 255));
            endcase
            open_string(q, rand_plain(q));
            repeat ($urandom_range(0, 10) == 0 ? $urandom_range(12, 40)
                                               : $urandom_range(0, 8))
                send_token(q);

            case ($urandom_range(0, 11))
                0, 1, 2, 3, 4, 5, 6:
                    send_body(q);
                7:
                    send_eoi();
                8:
                    ;   // left open: next begin drops it
                9:
                begin
                    send_body(CHAR_BSLASH);
                    if ($urandom_range(0, 1) == 0)
                        send_body(CHAR_NUL);
                    else
                        send_eoi();
                end
                10:
                begin
                    send_body(CHAR_BSLASH);
                    send_body(CHAR_X);
                    if ($urandom_range(0, 1) == 0)
                        send_body(rand_non_hex());
                    else
                        send_eoi();
                end
                default:
                begin
                    send_body(CHAR_BSLASH);
                    send_body(CHAR_X);
                    send_body(rand_hex_digit());
                    send_eoi();
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        rst_n              = 1'b0;
        byte_valid         = 1'b0;
        byte_item          = '0;
        long_hold_req      = 1'b0;
        src_idle_on        = 1'b1;
        res_idle_on        = 1'b1;
        err_count          = 0;
        decoded_items      = 0;
        strings_opened     = 0;
        results_checked    = 0;
        input_stall_cycles = 0;
        kind_count         = '{0, 0, 0, 0};
        str_mode           = MODE_IDLE;
        hex_hi             = 4'h0;
        quote_q            = 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plain_bytes();
        test_escapes();
        test_hex_escapes();
        test_endings();
        test_backpressure();
        test_random_strings(TARGET_ITEMS);

        @(negedge clk);
        byte_valid = 1'b0;
        while (decoded_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d items over %0d strings; %0d cycles with the input held off",
                 decoded_items, strings_opened, input_stall_cycles);
        $display("Checked %0d results: %0d data, %0d quote, %0d end of input, %0d bad escape",
                 results_checked, kind_count[KIND_DATA], kind_count[KIND_QUOTE],
                 kind_count[KIND_EOI], kind_count[KIND_BAD]);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
